/* rtl/lome_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_pkg
// Shared types and constants for the limit order matching engine.
// ----------------------------------------------------------------------------
package lome_pkg;

  localparam int NumUsers   = 16;
  localparam int NumAssets  = 8;
  localparam int BookDepth  = 16;
  localparam int UserW      = 4;
  localparam int AssetW     = 3;
  localparam int SlotW      = 4;
  localparam int FillW      = 5;
  localparam int BalW       = 48;
  localparam int BalAddrW   = UserW + AssetW;
  localparam int BookAddrW  = AssetW + SlotW;
  localparam int EntryW     = 16 + 16 + UserW + 1;
  localparam logic [BalW-1:0] BalMax = {BalW{1'b1}};

  typedef enum logic [1:0] {
    OP_DEPOSIT  = 2'd0,
    OP_WITHDRAW = 2'd1,
    OP_ORDER    = 2'd2,
    OP_NONE     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNKNOWN   = 3'd1,
    ST_NO_FUNDS  = 3'd2,
    ST_BOOK_FULL = 3'd3,
    ST_BAD_ASSET = 3'd4
  } status_e;

  // execution side sequencer
  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_BREAD, S_BUPD, S_MUL, S_ESCROW, S_RD, S_EVAL,
    S_CRB, S_CRS, S_SHRD, S_CMPRD, S_SHWR, S_APPEND, S_STATUS
  } state_e;

  // classified item passed from front to back
  typedef struct packed {
    op_e                op;
    logic               reject;
    status_e            status;
    logic [UserW-1:0]   user;
    logic [AssetW-1:0]  asset;
    logic               side;
    logic [15:0]        qty;
    logic [15:0]        price;
  } item_t;

  typedef struct packed {
    logic [15:0]       qty;
    logic [15:0]       price;
    logic [UserW-1:0]  owner;
    logic              side;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/lome_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module lome_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* rtl/lome_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_front
// Accepts commands, checks user and asset, and pushes them into a two-entry
// queue toward the execution side.
// ----------------------------------------------------------------------------
module lome_front import lome_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [UserW-1:0]  user_id_i,
  input  wire logic [AssetW-1:0] asset_id_i,
  input  wire logic              side_i,
  input  wire logic [15:0]       quantity_i,
  input  wire logic [15:0]       limit_price_i,
  output item_t                  item_o,
  output logic                   item_valid_o,
  input  wire logic              item_pop_i
);
  logic [NumUsers-1:0] known_q, known_d;
  item_t               q_q [2];
  logic [1:0]          cnt_q, cnt_d;
  logic                push;
  item_t               cls;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;

  always_comb begin
    cls.op     = op_e'(opcode_i);
    cls.user   = user_id_i;
    cls.asset  = asset_id_i;
    cls.side   = side_i;
    cls.qty    = quantity_i;
    cls.price  = limit_price_i;
    cls.reject = 1'b1;
    cls.status = ST_OK;
    known_d    = known_q;
    unique case (cls.op)
      OP_NONE: ;
      OP_DEPOSIT: begin
        cls.reject = 1'b0;
        known_d[user_id_i] = 1'b1;
      end
      OP_WITHDRAW: begin
        if (!known_q[user_id_i]) cls.status = ST_UNKNOWN;
        else cls.reject = 1'b0;
      end
      OP_ORDER: begin
        if (!known_q[user_id_i]) cls.status = ST_UNKNOWN;
        else if (asset_id_i == '0) cls.status = ST_BAD_ASSET;
        else cls.reject = 1'b0;
      end
      default: ;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, item_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      known_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (push) known_q <= known_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push && (cnt_q == 2'd0 || (cnt_q == 2'd1 && item_pop_i))) q_q[0] <= cls;
    else if (item_pop_i) q_q[0] <= q_q[1];
    if (push && cnt_q == 2'd1 && !item_pop_i) q_q[1] <= cls;
  end

  assign item_o       = q_q[0];
  assign item_valid_o = (cnt_q != 2'd0);

  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("queue count overflow");
  a_no_under: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_pop_i |-> cnt_q != 2'd0) else $error("pop from empty queue");
  a_busy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2 && !item_pop_i) |=> busy) else $error("busy dropped");
endmodule
`default_nettype wire

/* rtl/lome_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lome_back
// Executes one item at a time: balance updates, escrow, book walk with
// in-place compaction, append, then the status item.
// ----------------------------------------------------------------------------
module lome_back import lome_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  item_t                  item_i,
  input  wire logic              item_valid_i,
  output logic                   item_pop_o,
  output logic                   valid_o,
  output logic                   kind_o,
  output logic [2:0]             status_o,
  output logic [UserW-1:0]       buyer_id_o,
  output logic [UserW-1:0]       seller_id_o,
  output logic [AssetW-1:0]      trade_asset_o,
  output logic [15:0]            trade_quantity_o,
  output logic [15:0]            trade_price_o,
  output logic                   last_o
);
  state_e                state_q, state_d;
  item_t                 it_q;
  logic [NumAssets-1:0][FillW-1:0] fill_q;
  logic                  clr_q;
  logic [BalAddrW-1:0]   clr_cnt_q;
  logic [FillW-1:0]      fl_q, i_q, j_q;
  logic [15:0]           rem_q, tq_q;
  logic [31:0]           prod_q;
  entry_t                ent_q;
  status_e               st_q;

  // balance RAM
  logic                  bal_we;
  logic [BalAddrW-1:0]   bal_addr;
  logic [BalW-1:0]       bal_wd, bal_rd;
  // book RAM
  logic                  bk_we;
  logic [BookAddrW-1:0]  bk_addr;
  entry_t                bk_wd, bk_rd;
  logic [EntryW-1:0]     bk_rd_raw;

  lome_ram #(.Width(BalW), .Depth(NumUsers*NumAssets)) u_bal (
    .clk_i, .we_i(bal_we), .addr_i(bal_addr), .wdata_i(bal_wd), .rdata_o(bal_rd));
  lome_ram #(.Width(EntryW), .Depth(NumAssets*BookDepth)) u_book (
    .clk_i, .we_i(bk_we), .addr_i(bk_addr), .wdata_i(bk_wd), .rdata_o(bk_rd_raw));
  assign bk_rd = entry_t'(bk_rd_raw);

  logic [BalW-1:0] amt;     // escrow amount debited for an order
  logic            match;
  logic [15:0]     tq_c;
  logic [UserW-1:0] other_c;
  assign match = it_q.side ? (bk_rd.side == 1'b0 && it_q.price <= bk_rd.price)
                           : (bk_rd.side == 1'b1 && it_q.price >= bk_rd.price);
  assign tq_c  = (rem_q < bk_rd.qty) ? rem_q : bk_rd.qty;
  assign other_c = ent_q.owner;

  function automatic logic [BalW-1:0] sat_add(logic [BalW-1:0] b, logic [BalW-1:0] a);
    logic [BalW:0] s;
    s = {1'b0, b} + {1'b0, a};
    return s[BalW] ? BalMax : s[BalW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      fill_q    <= '0;
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (&clr_cnt_q) clr_q <= 1'b0;
      end
      if (state_q == S_STATUS && it_q.op == OP_ORDER && !it_q.reject &&
          st_q != ST_NO_FUNDS)
        fill_q[it_q.asset] <= fl_q;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        it_q <= item_i;
        st_q <= item_i.status;
      end
      S_INIT: begin
        fl_q  <= fill_q[it_q.asset];
        i_q   <= '0;
        rem_q <= it_q.qty;
        prod_q <= 32'(it_q.qty) * 32'(it_q.price);
      end
      S_BUPD: begin
        if (it_q.op == OP_WITHDRAW && bal_rd < {32'd0, it_q.qty}) st_q <= ST_NO_FUNDS;
      end
      S_ESCROW: begin
        if (bal_rd < amt) st_q <= ST_NO_FUNDS;
      end
      S_EVAL: begin
        ent_q <= bk_rd;
        tq_q  <= tq_c;
        if (match) prod_q <= 32'(tq_c) * 32'(bk_rd.price);
      end
      S_CRS: begin
        rem_q <= rem_q - tq_q;
        if (ent_q.qty == tq_q) begin
          j_q <= i_q;
          fl_q <= fl_q - 1'b1;
        end else i_q <= i_q + 1'b1;
      end
      S_SHWR: j_q <= j_q + 1'b1;
      S_APPEND: begin
        if (fl_q < FillW'(BookDepth)) fl_q <= fl_q + 1'b1;
        else st_q <= ST_BOOK_FULL;
      end
      default: ;
    endcase
    if (state_q == S_EVAL && !match) i_q <= i_q + 1'b1;
  end

  always_comb begin
    state_d    = state_q;
    item_pop_o = 1'b0;
    bal_we     = 1'b0;
    bal_addr   = {it_q.user, it_q.asset};
    bal_wd     = '0;
    bk_we      = 1'b0;
    bk_addr    = {it_q.asset, i_q[SlotW-1:0]};
    bk_wd      = ent_q;
    amt        = it_q.side ? {32'd0, it_q.qty} : {16'd0, prod_q};
    valid_o    = 1'b0;
    kind_o     = 1'b0;
    status_o   = st_q;
    buyer_id_o = '0;
    seller_id_o = '0;
    trade_asset_o = '0;
    trade_quantity_o = '0;
    trade_price_o = '0;
    last_o     = 1'b0;
    if (clr_q) begin
      bal_we   = 1'b1;
      bal_addr = clr_cnt_q;
    end
    unique case (state_q)
      S_IDLE: if (item_valid_i && !clr_q) begin
        item_pop_o = 1'b1;
        state_d = S_INIT;
      end
      S_INIT: begin
        if (it_q.reject) state_d = S_STATUS;
        else if (it_q.op == OP_ORDER) state_d = S_MUL;
        else state_d = S_BREAD;
      end
      S_BREAD: state_d = S_BUPD;
      S_BUPD: begin
        bal_we = 1'b1;
        if (it_q.op == OP_DEPOSIT) bal_wd = sat_add(bal_rd, {32'd0, it_q.qty});
        else if (bal_rd < {32'd0, it_q.qty}) bal_we = 1'b0;
        else bal_wd = bal_rd - {32'd0, it_q.qty};
        state_d = S_STATUS;
      end
      S_MUL: begin
        bal_addr = {it_q.user, it_q.side ? it_q.asset : AssetW'(0)};
        state_d = S_ESCROW;
      end
      S_ESCROW: begin
        bal_addr = {it_q.user, it_q.side ? it_q.asset : AssetW'(0)};
        if (bal_rd < amt) state_d = S_STATUS;
        else begin
          bal_we = 1'b1;
          bal_wd = bal_rd - amt;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (rem_q == '0) state_d = S_STATUS;
        else if (i_q >= fl_q) state_d = S_APPEND;
        else state_d = S_EVAL;
      end
      S_EVAL: begin
        // buyer asset address read issued for next cycle
        bal_addr = {it_q.side ? bk_rd.owner : it_q.user, it_q.asset};
        state_d = match ? S_CRB : S_RD;
      end
      S_CRB: begin
        bal_addr = {it_q.side ? other_c : it_q.user, it_q.asset};
        bal_we = 1'b1;
        bal_wd = sat_add(bal_rd, {32'd0, tq_q});
        valid_o = 1'b1;
        kind_o = 1'b1;
        status_o = ST_OK;
        buyer_id_o = it_q.side ? other_c : it_q.user;
        seller_id_o = it_q.side ? it_q.user : other_c;
        trade_asset_o = it_q.asset;
        trade_quantity_o = tq_q;
        trade_price_o = ent_q.price;
        state_d = S_SHRD;  // seller read
      end
      S_SHRD: begin
        bal_addr = {it_q.side ? it_q.user : other_c, AssetW'(0)};
        state_d = S_CRS;
      end
      S_CRS: begin
        bal_addr = {it_q.side ? it_q.user : other_c, AssetW'(0)};
        bal_we = 1'b1;
        bal_wd = sat_add(bal_rd, {16'd0, prod_q});
        bk_we = (ent_q.qty != tq_q);
        bk_wd = ent_q;
        bk_wd.qty = ent_q.qty - tq_q;
        state_d = (ent_q.qty == tq_q) ? S_CMPRD : S_RD;
      end
      S_CMPRD: begin
        // compaction: read j+1 here, write it to j in the next cycle
        if (j_q >= fl_q) state_d = S_RD;
        else begin
          bk_addr = {it_q.asset, j_q[SlotW-1:0] + SlotW'(1)};
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        bk_addr = {it_q.asset, j_q[SlotW-1:0]};
        bk_we = 1'b1;
        bk_wd = bk_rd;
        state_d = S_CMPRD;
      end
      S_APPEND: begin
        bk_addr = {it_q.asset, fl_q[SlotW-1:0]};
        bk_wd.qty = rem_q;
        bk_wd.price = it_q.price;
        bk_wd.owner = it_q.user;
        bk_wd.side = it_q.side;
        bk_we = (fl_q < FillW'(BookDepth));
        state_d = S_STATUS;
      end
      S_STATUS: begin
        valid_o = 1'b1;
        last_o = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !kind_o) else $error("last on a trade");
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE || state_q == S_INIT || fl_q <= FillW'(BookDepth))
    else $error("fill overflow");
  a_status_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_STATUS) |=> state_q == S_IDLE) else $error("status stuck");
endmodule
`default_nettype wire

/* rtl/limit_order_matching_engine_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// limit_order_matching_engine_top
// Per-user balances and per-asset resting order books with trade output.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy low; two commands may wait
// ahead of execution. Results appear with valid_o for one cycle each and
// cannot be stalled; the status item (last_o) ends each command. An order
// escrows its funds, then examines the resting entries in turn, trades on
// each match, moves up the entries behind a used-up resting order, and
// appends any remainder; the balance and book memories are single-port.
// After reset a pass clears all 128 balance entries before the first
// command executes.
module limit_order_matching_engine_top import lome_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        opcode_i,
  input  wire logic [UserW-1:0]  user_id_i,
  input  wire logic [AssetW-1:0] asset_id_i,
  input  wire logic              side_i,
  input  wire logic [15:0]       quantity_i,
  input  wire logic [15:0]       limit_price_i,
  output logic                   valid_o,
  output logic                   kind_o,
  output logic [2:0]             status_o,
  output logic [UserW-1:0]       buyer_id_o,
  output logic [UserW-1:0]       seller_id_o,
  output logic [AssetW-1:0]      trade_asset_o,
  output logic [15:0]            trade_quantity_o,
  output logic [15:0]            trade_price_o,
  output logic                   last_o
);
  item_t item;
  logic  item_valid, item_pop;

  lome_front u_front (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .user_id_i, .asset_id_i,
    .side_i, .quantity_i, .limit_price_i,
    .item_o(item), .item_valid_o(item_valid), .item_pop_i(item_pop));

  lome_back u_back (
    .clk_i, .rst_ni, .item_i(item), .item_valid_i(item_valid),
    .item_pop_o(item_pop), .valid_o, .kind_o, .status_o, .buyer_id_o,
    .seller_id_o, .trade_asset_o, .trade_quantity_o, .trade_price_o, .last_o);
endmodule
`default_nettype wire

/* bench/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Bench for the limit order matching engine: a local copy of the balances and
// order books predicts status and trade items, which are compared in order.
// ----------------------------------------------------------------------------
module tb import lome_pkg::*; ();

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [3:0]  buyer;
    logic [3:0]  seller;
    logic [2:0]  asset;
    logic [15:0] qty;
    logic [15:0] price;
    logic        last;
  } outcome_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic [1:0] opcode_i = '0;
  logic [3:0] user_id_i = '0;
  logic [2:0] asset_id_i = '0;
  logic side_i = 1'b0;
  logic [15:0] quantity_i = '0, limit_price_i = '0;
  logic busy, valid_o, kind_o, last_o;
  logic [2:0] status_o, trade_asset_o;
  logic [3:0] buyer_id_o, seller_id_o;
  logic [15:0] trade_quantity_o, trade_price_o;

  limit_order_matching_engine_top uut (.*);

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [47:0] acct_bal [NumUsers*NumAssets];
  logic        acct_open [NumUsers];
  logic [15:0] bk_qty [NumAssets][BookDepth];
  logic [15:0] bk_price [NumAssets][BookDepth];
  logic [3:0]  bk_owner [NumAssets][BookDepth];
  logic        bk_side [NumAssets][BookDepth];
  int          bk_fill [NumAssets];

  outcome_t pending_q[$];
  int errors = 0, n_trades = 0, n_items = 0;
  int gap_pct = 0;

  task automatic report(string what, outcome_t got, outcome_t exp);
    errors++;
    $display("%0t MISMATCH %s: got %h expected %h", $realtime, what, got, exp);
  endtask

  function automatic void queue_result(outcome_t o);
    pending_q = {pending_q, o};
  endfunction

  function automatic void add_funds(int u, int a, logic [63:0] amt);
    logic [63:0] b;
    b = {16'd0, acct_bal[u*NumAssets+a]};
    if (amt >= 64'hFFFF_FFFF_FFFF - b) acct_bal[u*NumAssets+a] = BalMax;
    else acct_bal[u*NumAssets+a] = 48'(b + amt);
  endfunction

  function automatic bit take_funds(int u, int a, logic [63:0] amt);
    if ({16'd0, acct_bal[u*NumAssets+a]} < amt) return 1'b0;
    acct_bal[u*NumAssets+a] -= amt[47:0];
    return 1'b1;
  endfunction

  function automatic void push_trade(int b, int s, int a, int q, int p);
    outcome_t o;
    o = '0;
    o.kind = 1'b1; o.buyer = 4'(b); o.seller = 4'(s); o.asset = 3'(a);
    o.qty = 16'(q); o.price = 16'(p);
    queue_result(o);
    n_trades++;
  endfunction

  function automatic void match_order(op_e op, int u, int a, bit sd, int q, int p);
    status_e st;
    outcome_t o;
    int i, rem, fill, tq;
    bit hit, ok;
    st = ST_OK;
    if (op == OP_NONE) st = ST_OK;
    else if (u >= NumUsers) st = ST_UNKNOWN;
    else if (op == OP_DEPOSIT) begin
      if (a >= NumAssets) st = ST_BAD_ASSET;
      else begin
        acct_open[u] = 1'b1;
        add_funds(u, a, 64'(q));
      end
    end else if (!acct_open[u]) st = ST_UNKNOWN;
    else if (op == OP_WITHDRAW) begin
      if (a >= NumAssets) st = ST_BAD_ASSET;
      else if (!take_funds(u, a, 64'(q))) st = ST_NO_FUNDS;
    end else if (a == 0 || a >= NumAssets) st = ST_BAD_ASSET;
    else begin
      ok = sd ? take_funds(u, a, 64'(q)) : take_funds(u, 0, 64'(q) * 64'(p));
      if (!ok) st = ST_NO_FUNDS;
      else begin
        fill = bk_fill[a];
        rem = q;
        i = 0;
        while (i < fill && rem > 0) begin
          hit = sd == 0 ? (bk_side[a][i] == 1 && p >= bk_price[a][i])
                        : (bk_side[a][i] == 0 && p <= bk_price[a][i]);
          if (!hit) begin
            i++;
            continue;
          end
          tq = rem < int'(bk_qty[a][i]) ? rem : int'(bk_qty[a][i]);
          add_funds(sd ? int'(bk_owner[a][i]) : u, a, 64'(tq));
          add_funds(sd ? u : int'(bk_owner[a][i]), 0, 64'(tq) * 64'(bk_price[a][i]));
          push_trade(sd ? int'(bk_owner[a][i]) : u, sd ? u : int'(bk_owner[a][i]),
                     a, tq, int'(bk_price[a][i]));
          bk_qty[a][i] = bk_qty[a][i] - 16'(tq);
          rem -= tq;
          if (bk_qty[a][i] == 0) begin
            for (int j = i; j + 1 < fill; j++) begin
              bk_qty[a][j] = bk_qty[a][j+1];
              bk_price[a][j] = bk_price[a][j+1];
              bk_owner[a][j] = bk_owner[a][j+1];
              bk_side[a][j] = bk_side[a][j+1];
            end
            fill--;
          end else i++;
        end
        if (rem > 0) begin
          if (fill < BookDepth) begin
            bk_qty[a][fill] = 16'(rem); bk_price[a][fill] = 16'(p);
            bk_owner[a][fill] = 4'(u); bk_side[a][fill] = sd;
            fill++;
          end else st = ST_BOOK_FULL;
        end
        bk_fill[a] = fill;
      end
    end
    o = '0;
    o.status = st;
    o.last = 1'b1;
    queue_result(o);
  endfunction

  // one item: optional random gap, then hold start until accepted
  task automatic send_item(op_e op, int u, int a, bit sd, int q, int p);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    opcode_i <= op; user_id_i <= 4'(u); asset_id_i <= 3'(a); side_i <= sd;
    quantity_i <= 16'(q); limit_price_i <= 16'(p);
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    match_order(op, u, a, sd, q, p);
    n_items++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    outcome_t got, exp;
    if (rst_ni && valid_o) begin
      got = {kind_o, status_o, buyer_id_o, seller_id_o, trade_asset_o,
             trade_quantity_o, trade_price_o, last_o};
      if (pending_q.size() == 0) report("unexpected item", got, '0);
      else begin
        exp = pending_q.pop_front();
        if (got.kind !== exp.kind) report("kind", got, exp);
        if (got.status !== exp.status) report("status", got, exp);
        if (got.buyer !== exp.buyer) report("buyer", got, exp);
        if (got.seller !== exp.seller) report("seller", got, exp);
        if (got.asset !== exp.asset) report("asset", got, exp);
        if (got.qty !== exp.qty) report("quantity", got, exp);
        if (got.price !== exp.price) report("price", got, exp);
        if (got.last !== exp.last) report("last", got, exp);
      end
    end
  end

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_directed();
    send_item(OP_WITHDRAW, 3, 0, 0, 1, 0);        // unknown user
    send_item(OP_NONE, 15, 7, 1, 16'hFFFF, 16'hFFFF);
    send_item(OP_DEPOSIT, 1, 0, 0, 0, 0);         // zero deposit opens account
    send_item(OP_DEPOSIT, 1, 0, 0, 16'hFFFF, 0);
    send_item(OP_DEPOSIT, 2, 3, 0, 500, 0);
    send_item(OP_DEPOSIT, 15, 7, 0, 16'hFFFF, 0);
    send_item(OP_WITHDRAW, 1, 0, 0, 16'hFFFF, 0);
    send_item(OP_WITHDRAW, 1, 0, 0, 1, 0);        // short balance
    send_item(OP_DEPOSIT, 1, 0, 0, 60000, 0);
    send_item(OP_ORDER, 1, 0, 0, 1, 1);           // order on USD
    send_item(OP_ORDER, 1, 3, 0, 10, 10000);      // escrow too big
    send_item(OP_ORDER, 2, 3, 1, 100, 5);
    send_item(OP_ORDER, 2, 3, 1, 0, 5);           // zero quantity
    send_item(OP_ORDER, 1, 3, 0, 30, 9);          // price improvement
    send_item(OP_ORDER, 2, 3, 0, 20, 6);          // self trade
    send_item(OP_ORDER, 1, 3, 0, 100, 4);         // rests as bid
    send_item(OP_ORDER, 2, 3, 1, 70, 4);
    for (int k = 0; k < 20; k++)
      send_item(OP_DEPOSIT, 15, 0, 0, 16'hFFFF, 0); // USD for the sweep
    for (int k = 0; k < 18; k++)
      send_item(OP_ORDER, 15, 7, 1, 1, 16'hFFFF);   // fills, then book full
    send_item(OP_ORDER, 15, 7, 0, 20, 16'hFFFF);    // sweeps book
    drain();
  endtask

  task automatic test_random(int n, int gap);
    int op, u, a, r;
    gap_pct = gap;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      u = $urandom_range(99) < 90 ? $urandom_range(5) : $urandom_range(15);
      a = $urandom_range(99) < 85 ? $urandom_range(3, 1) : $urandom_range(7);
      if (r < 25) send_item(OP_DEPOSIT, u, a, 1'($urandom_range(1)),
                            $urandom_range(99) < 10 ? $urandom_range(65535)
                                                    : $urandom_range(2000),
                            $urandom_range(65535));
      else if (r < 33) send_item(OP_WITHDRAW, u, a, 1'($urandom_range(1)),
                                 $urandom_range(300), $urandom_range(65535));
      else if (r < 35) send_item(OP_NONE, $urandom_range(15), $urandom_range(7),
                                 1'($urandom_range(1)), $urandom_range(65535),
                                 $urandom_range(65535));
      else send_item(OP_ORDER, u, a, 1'($urandom_range(1)),
                     $urandom_range(99) < 5 ? $urandom_range(65535)
                                            : $urandom_range(40),
                     $urandom_range(99) < 5 ? $urandom_range(65535)
                                            : $urandom_range(20, 5));
    end
  endtask

  initial begin
    for (int i = 0; i < NumUsers*NumAssets; i++) acct_bal[i] = '0;
    for (int i = 0; i < NumUsers; i++) acct_open[i] = 1'b0;
    for (int i = 0; i < NumAssets; i++) bk_fill[i] = 0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(105, 0);
    test_random(105, 75);
    drain();                         // sender holds off until all results are in
    test_random(105, 27);
    test_random(99, 0);
    drain();
    repeat (100) @(negedge clk_i);
    $display("Covered %0d items (directed and random, with sender gaps)", n_items);
    $display("and %0d trades across deposits, withdrawals and limit orders.", n_trades);
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule
